// ===== rtl/rgbca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbca_pkg - shared types and constants for the RGB colour adjust unit
// Operation codes, luminance coefficients, stage enables and palette helpers.
// ----------------------------------------------------------------------------
package rgbca_pkg;

	typedef enum logic [2:0] {
		KIND_LIGHTEN    = 3'd0,
		KIND_DARKEN     = 3'd1,
		KIND_SATURATE   = 3'd2,
		KIND_DESATURATE = 3'd3,
		KIND_COMPLEMENT = 3'd4,
		KIND_GRAYSCALE  = 3'd5,
		KIND_MIX        = 3'd6
	} kind_t;

	// per-stage load enables, shared by the top level and the channel lanes
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} adv_t;

	// 0.299, 0.587, 0.114 in Q0.16, summing to exactly 65536
	localparam logic [15:0] LUMA_CR = 16'd19595;
	localparam logic [15:0] LUMA_CG = 16'd38470;
	localparam logic [15:0] LUMA_CB = 16'd7471;

	localparam logic [8:0] ONE_Q8 = 9'd256;

	localparam logic [7:0] PAL_CUBE_BASE = 8'd16;
	localparam logic [7:0] PAL_GRAY_LOW  = 8'd16;
	localparam logic [7:0] PAL_GRAY_HIGH = 8'd231;
	localparam logic [8:0] PAL_RAMP_BASE = 9'd232;
	localparam logic [7:0] PAL_RAMP_MAX  = 8'd255;

	// (c*5)/255 as a compare ladder
	function automatic logic [2:0] cube_level(input logic [7:0] c);
		logic [2:0] lvl;
		if (c == 8'd255)      lvl = 3'd5;
		else if (c >= 8'd204) lvl = 3'd4;
		else if (c >= 8'd153) lvl = 3'd3;
		else if (c >= 8'd102) lvl = 3'd2;
		else if (c >= 8'd51)  lvl = 3'd1;
		else                  lvl = 3'd0;
		return lvl;
	endfunction

	// grey ramp entry; divide by ten as *205 >> 11, exact for 0..240
	function automatic logic [7:0] gray_index(input logic [7:0] v);
		logic [7:0]  x;
		logic [15:0] p;
		logic [8:0]  idx;
		logic [7:0]  res;
		x   = v - 8'd8;
		p   = 16'(x) * 16'd205;
		idx = PAL_RAMP_BASE + 9'(p[15:11]);
		if (v < 8'd8)
			res = PAL_GRAY_LOW;
		else if (v > 8'd248)
			res = PAL_GRAY_HIGH;
		else if (idx[8])
			res = PAL_RAMP_MAX;
		else
			res = idx[7:0];
		return res;
	endfunction

endpackage

// ===== rtl/rgbca_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbca_lane - one colour channel of the adjust pipeline
// Mix-style ops, the luminance-relative gain, complement and grey, four register stages.
// ----------------------------------------------------------------------------
module rgbca_lane (
	input  logic                clk,
	input  rgbca_pkg::adv_t     adv,
	input  rgbca_pkg::kind_t    kind,
	input  logic [7:0]          c,
	input  logic [7:0]          o,
	input  logic [8:0]          w,
	input  logic [23:0]         lum_s1,
	input  logic [23:0]         lum_s3,
	output logic [7:0]          res_s4
);

	logic [7:0]          o_sel;
	logic [8:0]          inv_w;
	logic [16:0]         mix_sum;
	logic [9:0]          gain;

	rgbca_pkg::kind_t    kind_s1, kind_s2, kind_s3;
	logic [7:0]          c_s1, c_s2, c_s3;
	logic [16:0]         mix_sum_s1;
	logic [9:0]          gain_s1, gain_s2;
	logic [7:0]          mix_s2, mix_s3;
	logic signed [24:0]  diff_s2;
	logic signed [35:0]  prod_s3;

	logic signed [36:0]  acc;
	logic [7:0]          gain_res;
	logic [7:0]          res;

	// lighten is a mix towards white, darken a mix towards black
	always_comb begin
		case (kind)
			rgbca_pkg::KIND_LIGHTEN: o_sel = 8'hFF;
			rgbca_pkg::KIND_DARKEN:  o_sel = 8'h00;
			default:                 o_sel = o;
		endcase
		inv_w   = rgbca_pkg::ONE_Q8 - w;
		mix_sum = 17'(c) * 17'(inv_w) + 17'(o_sel) * 17'(w);
		gain    = (kind == rgbca_pkg::KIND_SATURATE) ?
			10'(rgbca_pkg::ONE_Q8) + 10'(w) : 10'(rgbca_pkg::ONE_Q8) - 10'(w);
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			kind_s1    <= kind;
			c_s1       <= c;
			mix_sum_s1 <= mix_sum;
			gain_s1    <= gain;
		end
		if (adv.s2) begin
			kind_s2 <= kind_s1;
			c_s2    <= c_s1;
			mix_s2  <= mix_sum_s1[15:8];
			gain_s2 <= gain_s1;
			diff_s2 <= $signed({1'b0, c_s1, 16'h0000}) - $signed({1'b0, lum_s1});
		end
		if (adv.s3) begin
			kind_s3 <= kind_s2;
			c_s3    <= c_s2;
			mix_s3  <= mix_s2;
			prod_s3 <= 36'(diff_s2) * 36'($signed({1'b0, gain_s2}));
		end
		if (adv.s4)
			res_s4 <= res;
	end

	// Q.24 accumulation, clamp to 0..255
	always_comb begin
		acc = $signed({5'b0, lum_s3, 8'h00}) + 37'(prod_s3);
		if (acc[36])
			gain_res = 8'h00;
		else if (|acc[35:32])
			gain_res = 8'hFF;
		else
			gain_res = acc[31:24];

		case (kind_s3) inside
			rgbca_pkg::KIND_LIGHTEN, rgbca_pkg::KIND_DARKEN, rgbca_pkg::KIND_MIX:
				res = mix_s3;
			rgbca_pkg::KIND_SATURATE, rgbca_pkg::KIND_DESATURATE:
				res = gain_res;
			rgbca_pkg::KIND_COMPLEMENT:
				res = ~c_s3;
			rgbca_pkg::KIND_GRAYSCALE:
				res = lum_s3[23:16];
			default:
				res = c_s3;
		endcase
	end

endmodule

// ===== rtl/rgb_color_adjust_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_color_adjust_unit - RGB pixel adjuster with xterm-256 quantisation
// Four-stage pipeline: colour operation, luminance, dark flag, palette index.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests arrive on s_axis_*: tuser carries the operation code,
//   tdata the pixel, the second pixel and the Q0.8 weight. One result
//   request per input leaves on m_axis_*.
//   Four register stages lie between an accepted request and its result
//   on m_axis_*. Throughput is one pixel per cycle while the receiver
//   takes results, as every stage loads in the cycle it hands on.
//   Each stage has its own valid bit and loads whenever it is empty or the
//   stage after it moves, so bubbles are squeezed out while the receiver
//   stalls and s_axis_tready drops only once all four stages hold data.
//   A stalled result holds its data until taken.
//   Reset clears every valid bit; the unit keeps no other state.
//   Operation code 7 passes the pixel through unchanged; weights above 256
//   act as 256.
// ----------------------------------------------------------------------------
module rgb_color_adjust_unit (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// red[7:0], green[15:8], blue[23:16], other_red[31:24],
	// other_green[39:32], other_blue[47:40], weight[56:48], zero fill
	input  logic [63:0] s_axis_tdata,
	// kind[2:0]
	input  logic [2:0]  s_axis_tuser,

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// out_red[7:0], out_green[15:8], out_blue[23:16], luma[31:24],
	// is_dark[32], palette_index[40:33], zero fill
	output logic [47:0] m_axis_tdata
);

	logic               v_s1, v_s2, v_s3, v_s4;
	rgbca_pkg::adv_t    adv;

	rgbca_pkg::kind_t   kind;
	logic [7:0]         red, green, blue;
	logic [8:0]         w_raw, w;
	logic [23:0]        lum;

	logic [23:0]        lum_s1, lum_s2, lum_s3;
	logic               gray_s1;
	logic [7:0]         gray_idx_s1;
	logic [2:0]         ri_s1, gi_s1, bi_s1;
	logic [7:0]         pal_s2, pal_s3, pal_s4;
	logic [7:0]         luma_s4;
	logic               dark_s4;
	logic [7:0]         res_r_s4, res_g_s4, res_b_s4;

	// stage enables: load when empty or when the next stage moves on
	always_comb begin
		adv.s4 = !v_s4 || m_axis_tready;
		adv.s3 = !v_s3 || adv.s4;
		adv.s2 = !v_s2 || adv.s3;
		adv.s1 = !v_s1 || adv.s2;
	end

	assign s_axis_tready = adv.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv.s1) v_s1 <= s_axis_tvalid;
			if (adv.s2) v_s2 <= v_s1;
			if (adv.s3) v_s3 <= v_s2;
			if (adv.s4) v_s4 <= v_s3;
		end
	end

	always_comb begin
		kind  = rgbca_pkg::kind_t'(s_axis_tuser);
		red   = s_axis_tdata[7:0];
		green = s_axis_tdata[15:8];
		blue  = s_axis_tdata[23:16];
		w_raw = s_axis_tdata[56:48];
		w     = (w_raw > rgbca_pkg::ONE_Q8) ? rgbca_pkg::ONE_Q8 : w_raw;
		lum   = 24'(red) * 24'(rgbca_pkg::LUMA_CR) + 24'(green) * 24'(rgbca_pkg::LUMA_CG)
			+ 24'(blue) * 24'(rgbca_pkg::LUMA_CB);
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			lum_s1      <= lum;
			gray_s1     <= (red == green) && (green == blue);
			gray_idx_s1 <= rgbca_pkg::gray_index(red);
			ri_s1       <= rgbca_pkg::cube_level(red);
			gi_s1       <= rgbca_pkg::cube_level(green);
			bi_s1       <= rgbca_pkg::cube_level(blue);
		end
		if (adv.s2) begin
			lum_s2 <= lum_s1;
			pal_s2 <= gray_s1 ? gray_idx_s1 :
				rgbca_pkg::PAL_CUBE_BASE + 8'(ri_s1) * 8'd36 + 8'(gi_s1) * 8'd6 + 8'(bi_s1);
		end
		if (adv.s3) begin
			lum_s3 <= lum_s2;
			pal_s3 <= pal_s2;
		end
		if (adv.s4) begin
			pal_s4  <= pal_s3;
			luma_s4 <= lum_s3[23:16];
			dark_s4 <= !lum_s3[23];
		end
	end

	rgbca_lane u_lane_r (
		.clk    (clk),
		.adv    (adv),
		.kind   (kind),
		.c      (red),
		.o      (s_axis_tdata[31:24]),
		.w      (w),
		.lum_s1 (lum_s1),
		.lum_s3 (lum_s3),
		.res_s4 (res_r_s4)
	);

	rgbca_lane u_lane_g (
		.clk    (clk),
		.adv    (adv),
		.kind   (kind),
		.c      (green),
		.o      (s_axis_tdata[39:32]),
		.w      (w),
		.lum_s1 (lum_s1),
		.lum_s3 (lum_s3),
		.res_s4 (res_g_s4)
	);

	rgbca_lane u_lane_b (
		.clk    (clk),
		.adv    (adv),
		.kind   (kind),
		.c      (blue),
		.o      (s_axis_tdata[47:40]),
		.w      (w),
		.lum_s1 (lum_s1),
		.lum_s3 (lum_s3),
		.res_s4 (res_b_s4)
	);

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata  = {7'h00, pal_s4, dark_s4, luma_s4, res_b_s4, res_g_s4, res_r_s4};

	// an empty output stage means the whole pipe can move
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output stage");

	// a result only appears behind a valid item in stage three
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s4) |-> $past(v_s3))
		else $error("output valid without a preceding item");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[40:33] >= rgbca_pkg::PAL_CUBE_BASE))
		else $error("palette index below the colour cube");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[32] == !m_axis_tdata[31]))
		else $error("dark flag disagrees with luma");

endmodule
